FILE: hw/rtl/acdna_pkg.sv
// Shared constants and types for the DNA Aho-Corasick automaton builder.
package acdna_pkg;

	localparam int NODES       = 128;
	localparam int ALPHABET    = 4;
	localparam int NODE_W      = 7;
	localparam int SYM_W       = 2;
	localparam int COUNT_W     = 8;
	localparam int CHILD_DEPTH = NODES * ALPHABET;
	localparam int CHILD_AW    = 9;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_BUILD  = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_MARK,
		ST_B_ROOT,
		ST_B_ROOTCHK,
		ST_B_POP,
		ST_B_CUR,
		ST_B_FL,
		ST_B_FLBAD,
		ST_B_K,
		ST_B_KD,
		ST_B_V
	} state_t;

endpackage

FILE: hw/rtl/acdna_ram.sv
// Generic single-port synchronous RAM with a registered read.
module acdna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/aho_corasick_dna_builder_core.sv
// Top level of the DNA Aho-Corasick automaton builder.
// Insert and query give one result strobe each, also when an insert finds the table full;
// clear works through the child table one child entry a cycle.
// Build pace is set by the single-port child table, which serves two reads per symbol.
// One item is worked on at a time; busy covers it.
// Reset runs a clearing pass over the tables with busy high and no result beat.
module aho_corasick_dna_builder_core
	import acdna_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [SYM_W-1:0]   symbol,
	input  logic               last_of_pattern,
	input  logic [NODE_W-1:0]  from_node,
	output logic               result_valid,
	output logic [NODE_W-1:0]  node,
	output logic               forbidden,
	output logic [COUNT_W-1:0] node_count,
	output logic               full_res
);

	// Control state.
	state_t               state_q, state_d;
	logic [CHILD_AW-1:0]  cnt_q, cnt_d;
	logic                 reply_q, reply_d;
	logic [COUNT_W-1:0]   used_q, used_d;
	logic [NODE_W-1:0]    cursor_q, cursor_d;
	logic                 ins_q, ins_d;
	logic                 last_q, last_d;
	logic                 mark_q, mark_d;
	logic [CHILD_AW-1:0]  slot_q, slot_d;
	logic [NODE_W-1:0]    k_q, k_d;
	logic [NODE_W-1:0]    cur_q, cur_d;
	logic [NODE_W-1:0]    fl_q, fl_d;
	logic                 badc_q, badc_d;
	logic [SYM_W-1:0]     c_q, c_d;
	logic [COUNT_W-1:0]   head_q, head_d, tail_q, tail_d;

	// Result register: one beat per item, shown for a single cycle.
	logic                 valid_q, valid_d;
	logic [NODE_W-1:0]    node_q, node_d;
	logic                 forb_q, forb_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic                 full_q, full_d;

	// Memory ports.
	logic                 child_we, fail_we, bad_we, q_we;
	logic [CHILD_AW-1:0]  child_addr;
	logic [NODE_W-1:0]    fail_addr, bad_addr, q_addr;
	logic [NODE_W-1:0]    child_wd, fail_wd, q_wd;
	logic                 bad_wd;
	logic [NODE_W-1:0]    child_rd, fail_rd, q_rd;
	logic                 bad_rd;

	acdna_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
		.clk(clk), .we(child_we), .addr(child_addr), .wdata(child_wd), .rdata(child_rd)
	);
	acdna_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
		.clk(clk), .we(fail_we), .addr(fail_addr), .wdata(fail_wd), .rdata(fail_rd)
	);
	acdna_ram #(.WIDTH(1), .DEPTH(NODES)) u_bad (
		.clk(clk), .we(bad_we), .addr(bad_addr), .wdata(bad_wd), .rdata(bad_rd)
	);
	acdna_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cnt_q    <= '0;
			reply_q  <= 1'b0;
			used_q   <= COUNT_W'(1);
			cursor_q <= '0;
			ins_q    <= 1'b0;
			last_q   <= 1'b0;
			mark_q   <= 1'b0;
			c_q      <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			badc_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			reply_q  <= reply_d;
			used_q   <= used_d;
			cursor_q <= cursor_d;
			ins_q    <= ins_d;
			last_q   <= last_d;
			mark_q   <= mark_d;
			c_q      <= c_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			badc_q   <= badc_d;
			valid_q  <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q  <= slot_d;
		k_q     <= k_d;
		cur_q   <= cur_d;
		fl_q    <= fl_d;
		node_q  <= node_d;
		forb_q  <= forb_d;
		count_q <= count_d;
		full_q  <= full_d;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		reply_d  = reply_q;
		used_d   = used_q;
		cursor_d = cursor_q;
		ins_d    = ins_q;
		last_d   = last_q;
		mark_d   = mark_q;
		slot_d   = slot_q;
		k_d      = k_q;
		cur_d    = cur_q;
		fl_d     = fl_q;
		badc_d   = badc_q;
		c_d      = c_q;
		head_d   = head_q;
		tail_d   = tail_q;
		valid_d  = 1'b0;
		node_d   = node_q;
		forb_d   = forb_q;
		count_d  = count_q;
		full_d   = full_q;

		child_we   = 1'b0;
		child_addr = slot_q;
		child_wd   = '0;
		fail_we    = 1'b0;
		fail_addr  = cur_q;
		fail_wd    = '0;
		bad_we     = 1'b0;
		bad_addr   = cur_q;
		bad_wd     = 1'b0;
		q_we       = 1'b0;
		q_addr     = tail_q[NODE_W-1:0];
		q_wd       = k_q;

		case (state_q)
			ST_CLEAR: begin
				// Sweep: one child entry per cycle; the node tables ride on the low bits.
				child_we   = 1'b1;
				child_addr = cnt_q;
				fail_we    = 1'b1;
				fail_addr  = cnt_q[NODE_W-1:0];
				bad_we     = 1'b1;
				bad_addr   = cnt_q[NODE_W-1:0];
				cnt_d      = cnt_q + CHILD_AW'(1);
				if (cnt_q == CHILD_AW'(CHILD_DEPTH - 1)) begin
					used_d   = COUNT_W'(1);
					cursor_d = '0;
					reply_d  = 1'b0;
					state_d  = ST_IDLE;
					if (reply_q) begin
						valid_d = 1'b1;
						node_d  = '0;
						forb_d  = 1'b0;
						count_d = COUNT_W'(1);
						full_d  = 1'b0;
					end
				end
			end
			ST_IDLE: begin
				if (start) begin
					last_d = last_of_pattern;
					case (mode_t'(mode))
						MODE_CLEAR: begin
							cnt_d   = '0;
							reply_d = 1'b1;
							state_d = ST_CLEAR;
						end
						MODE_INSERT: begin
							ins_d      = 1'b1;
							slot_d     = {cursor_q, symbol};
							child_addr = {cursor_q, symbol};
							state_d    = ST_LOOK;
						end
						MODE_BUILD: begin
							c_d     = '0;
							head_d  = '0;
							tail_d  = '0;
							state_d = ST_B_ROOT;
						end
						MODE_QUERY: begin
							ins_d      = 1'b0;
							slot_d     = {from_node, symbol};
							child_addr = {from_node, symbol};
							state_d    = ST_LOOK;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOK: begin
				if (!ins_q) begin
					k_d      = child_rd;
					mark_d   = 1'b0;
					bad_addr = child_rd;
					state_d  = ST_MARK;
				end else if (child_rd == '0 && used_q == COUNT_W'(NODES)) begin
					// Table full: nothing is created and the pattern is abandoned.
					cursor_d = '0;
					valid_d  = 1'b1;
					node_d   = '0;
					forb_d   = 1'b0;
					count_d  = used_q;
					full_d   = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					if (child_rd == '0) begin
						// New nodes come out of a cleared region, so their rows are zero.
						k_d        = used_q[NODE_W-1:0];
						child_we   = 1'b1;
						child_addr = slot_q;
						child_wd   = used_q[NODE_W-1:0];
						used_d     = used_q + COUNT_W'(1);
					end else begin
						k_d = child_rd;
					end
					cursor_d = last_q ? '0 : k_d;
					mark_d   = last_q;
					bad_addr = k_d;
					state_d  = ST_MARK;
				end
			end
			ST_MARK: begin
				bad_addr = k_q;
				bad_we   = mark_q;
				bad_wd   = 1'b1;
				valid_d  = 1'b1;
				node_d   = k_q;
				forb_d   = mark_q | bad_rd;
				count_d  = used_q;
				full_d   = 1'b0;
				state_d  = ST_IDLE;
			end
			ST_B_ROOT: begin
				child_addr = {{NODE_W{1'b0}}, c_q};
				state_d    = ST_B_ROOTCHK;
			end
			ST_B_ROOTCHK: begin
				// Children of the root fail to the root and seed the walk.
				if (child_rd != '0 && tail_q < COUNT_W'(NODES)) begin
					fail_we   = 1'b1;
					fail_addr = child_rd;
					fail_wd   = '0;
					q_we      = 1'b1;
					q_wd      = child_rd;
					tail_d    = tail_q + COUNT_W'(1);
				end
				c_d     = c_q + SYM_W'(1);
				state_d = (c_q == SYM_W'(ALPHABET - 1)) ? ST_B_POP : ST_B_ROOT;
			end
			ST_B_POP: begin
				if (head_q == tail_q) begin
					cursor_d = '0;
					valid_d  = 1'b1;
					node_d   = '0;
					forb_d   = 1'b0;
					count_d  = used_q;
					full_d   = 1'b0;
					state_d  = ST_IDLE;
				end else begin
					q_addr  = head_q[NODE_W-1:0];
					head_d  = head_q + COUNT_W'(1);
					state_d = ST_B_CUR;
				end
			end
			ST_B_CUR: begin
				cur_d     = q_rd;
				fail_addr = q_rd;
				bad_addr  = q_rd;
				state_d   = ST_B_FL;
			end
			ST_B_FL: begin
				fl_d     = fail_rd;
				badc_d   = bad_rd;
				bad_addr = fail_rd;
				state_d  = ST_B_FLBAD;
			end
			ST_B_FLBAD: begin
				// A node whose failure node is forbidden is forbidden too.
				bad_addr = cur_q;
				bad_we   = bad_rd;
				bad_wd   = 1'b1;
				badc_d   = badc_q | bad_rd;
				c_d      = '0;
				state_d  = ST_B_K;
			end
			ST_B_K: begin
				child_addr = {cur_q, c_q};
				state_d    = ST_B_KD;
			end
			ST_B_KD: begin
				k_d        = child_rd;
				child_addr = {fl_q, c_q};
				state_d    = ST_B_V;
			end
			ST_B_V: begin
				if (k_q == '0) begin
					// Absent child takes the failure node's transition.
					child_we   = 1'b1;
					child_addr = {cur_q, c_q};
					child_wd   = child_rd;
				end else begin
					fail_we   = 1'b1;
					fail_addr = k_q;
					fail_wd   = child_rd;
					bad_we    = badc_q;
					bad_addr  = k_q;
					bad_wd    = 1'b1;
					if (tail_q < COUNT_W'(NODES)) begin
						q_we   = 1'b1;
						q_wd   = k_q;
						tail_d = tail_q + COUNT_W'(1);
					end
				end
				c_d     = c_q + SYM_W'(1);
				state_d = (c_q == SYM_W'(ALPHABET - 1)) ? ST_B_POP : ST_B_K;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign node         = node_q;
	assign forbidden    = forb_q;
	assign node_count   = count_q;
	assign full_res     = full_q;

endmodule

FILE: hw/rtl/acdna_checker.sv
// Port-level checker for the automaton builder, bound to the top level.
module acdna_checker
	import acdna_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input logic [NODE_W-1:0]  node,
	input logic [COUNT_W-1:0] node_count,
	input logic               full_res
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result beat longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result beat while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> node_count != '0 && node_count <= COUNT_W'(NODES))
		else $error("node count out of range");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && full_res |-> node == '0 && node_count == COUNT_W'(NODES))
		else $error("full flag with a node or a table that is not full");

endmodule

bind aho_corasick_dna_builder_core acdna_checker u_acdna_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .node(node), .node_count(node_count),
	.full_res(full_res)
);
